// ===== hdl/lcfb_pkg.sv =====
// Package: shared types and constants of the LED fade and breathing controller.
`default_nettype none

package lcfb_pkg;

    localparam int DUTY_W  = 8;
    localparam int CH_W    = 5;
    localparam int CFG_W   = 8;
    localparam int CFG_IDX_W = 2;
    localparam int ACT_W   = 2;
    localparam int TDATA_W = 16;
    // wide enough to compare any channel number, CHANNELS or POWER_CHANNEL
    localparam int CMP_W   = 7;

    localparam logic [DUTY_W-1:0] NORMAL_RESET   = 8'd255;
    localparam logic [DUTY_W-1:0] LOWLIGHT_RESET = 8'd32;
    localparam logic [DUTY_W-1:0] SLOW_RESET     = 8'd10;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWLIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW     = 2'd2;

    typedef enum logic [ACT_W-1:0] {
        ACT_TICK    = 2'd0,
        ACT_REFRESH = 2'd1,
        ACT_SET     = 2'd2,
        ACT_QUERY   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_STEP,
        WR_REFRESH,
        WR_SET
    } wr_op_t;

    typedef enum logic [1:0] {
        OUT_NONE,
        OUT_ROW,
        OUT_QUERY
    } out_op_t;

    typedef enum logic {
        RD_SWEEP,
        RD_ITEM
    } rd_sel_t;

    // one channel's stored state
    typedef struct packed {
        logic              sw;
        logic [DUTY_W-1:0] tgt;
        logic [DUTY_W-1:0] cur;
    } row_t;

    // controller -> datapath
    typedef struct packed {
        logic    item_load;
        logic    rd_en;
        rd_sel_t rd_sel;
        wr_op_t  wr_op;
        logic    idx_clr;
        logic    idx_inc;
        logic    pre_dec;
        logic    pre_reload;
        out_op_t out_op;
        logic    out_last;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic pre_zero;
        logic idx_last;
        logic ch_in_range;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// ===== hdl/lcfb_ctrl.sv =====
// Controller: sequences ticks, refresh sweeps, queries and switch writes.
`default_nettype none

module lcfb_ctrl
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire lcfb_pkg::action_t action,
    input  wire lcfb_pkg::status_t status,
    output lcfb_pkg::cmd_t         cmd
);
    import lcfb_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_STEP_SWEEP,
        ST_STEP_TAIL,
        ST_REF_SWEEP,
        ST_REF_TAIL,
        ST_EMIT_RD,
        ST_EMIT_WAIT,
        ST_QUERY_RD,
        ST_QUERY_WAIT,
        ST_SET_RD,
        ST_SET_WR
    } state_t;

    state_t state_reg, state_next;
    logic   wr_pend_reg, wr_pend_next;

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        wr_pend_next = wr_pend_reg;
        s_tready     = 1'b0;
        cmd          = '0;
        cmd.rd_sel   = RD_SWEEP;
        cmd.wr_op    = WR_NONE;
        cmd.out_op   = OUT_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready     = 1'b1;
                wr_pend_next = 1'b0;
                if (s_tvalid)
                begin
                    cmd.item_load = 1'b1;
                    unique case (action)
                        ACT_TICK:
                        begin
                            if (status.pre_zero)
                            begin
                                cmd.pre_reload = 1'b1;
                                cmd.idx_clr    = 1'b1;
                                state_next     = ST_STEP_SWEEP;
                            end
                            else
                            begin
                                cmd.pre_dec = 1'b1;
                            end
                        end
                        ACT_REFRESH:
                        begin
                            cmd.idx_clr = 1'b1;
                            state_next  = ST_REF_SWEEP;
                        end
                        ACT_SET:   state_next = ST_SET_RD;
                        ACT_QUERY: state_next = ST_QUERY_RD;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_STEP_SWEEP, ST_REF_SWEEP:
            begin
                // read row idx while writing back the row read last cycle
                cmd.rd_en    = 1'b1;
                cmd.rd_sel   = RD_SWEEP;
                wr_pend_next = 1'b1;
                if (wr_pend_reg)
                begin
                    cmd.wr_op = (state_reg == ST_STEP_SWEEP) ? WR_STEP : WR_REFRESH;
                end
                if (status.idx_last)
                begin
                    state_next = (state_reg == ST_STEP_SWEEP) ? ST_STEP_TAIL : ST_REF_TAIL;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            ST_STEP_TAIL:
            begin
                cmd.wr_op  = WR_STEP;
                state_next = ST_IDLE;
            end
            ST_REF_TAIL:
            begin
                cmd.wr_op   = WR_REFRESH;
                cmd.idx_clr = 1'b1;
                state_next  = ST_EMIT_RD;
            end
            ST_EMIT_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_SWEEP;
                state_next = ST_EMIT_WAIT;
            end
            ST_EMIT_WAIT:
            begin
                if (status.out_free)
                begin
                    cmd.out_op   = OUT_ROW;
                    cmd.out_last = status.idx_last;
                    if (status.idx_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = ST_EMIT_RD;
                    end
                end
            end
            ST_QUERY_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_ITEM;
                state_next = ST_QUERY_WAIT;
            end
            ST_QUERY_WAIT:
            begin
                if (status.out_free)
                begin
                    cmd.out_op   = OUT_QUERY;
                    cmd.out_last = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_SET_RD:
            begin
                if (status.ch_in_range)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_ITEM;
                    state_next = ST_SET_WR;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SET_WR:
            begin
                cmd.wr_op  = WR_SET;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            wr_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            wr_pend_reg <= wr_pend_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/lcfb_datapath.sv =====
// Datapath: channel memory, prescaler, speed, config registers and result register.
`default_nettype none

module lcfb_datapath
#(
    parameter int CHANNELS      = 17,
    parameter int POWER_CHANNEL = 3
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [lcfb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [lcfb_pkg::CFG_W-1:0]       cfg_data,
    // channel[4:0], switch_on[5], highlight[6], update_now[7], power_on[8], zero fill
    input  wire logic [lcfb_pkg::TDATA_W-1:0]     s_tdata,
    input  wire lcfb_pkg::cmd_t                   cmd,
    output lcfb_pkg::status_t                     status,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // out_channel[4:0], duty[12:5], reached[13], all_reached[14], zero fill
    output logic [lcfb_pkg::TDATA_W-1:0]          m_tdata,
    output logic                                  m_tlast
);
    import lcfb_pkg::*;

    localparam int IW    = $clog2(CHANNELS);
    localparam int CW    = (IW > CH_W) ? IW : CH_W;
    localparam int CNT_W = $clog2(CHANNELS + 1);

    // configuration registers
    logic [DUTY_W-1:0] normal_reg, lowlight_reg, slow_reg;

    // latched item fields
    logic [CH_W-1:0] item_ch_reg;
    logic            item_sw_reg, item_hl_reg, item_now_reg, item_pwr_reg;

    // control state
    logic [DUTY_W-1:0] speed_reg, speed_next;
    logic [DUTY_W-1:0] pre_reg;
    logic [IW-1:0]     idx_reg;
    logic [CNT_W-1:0]  miss_cnt_reg;
    logic [CHANNELS-1:0] valid_reg;

    // channel memory and its read port
    row_t          row_mem_reg [CHANNELS];
    row_t          rd_row_reg;
    logic          rd_vld_reg;
    logic [IW-1:0] rd_addr_reg;

    // output register
    logic              out_vld_reg;
    logic [CH_W-1:0]   out_ch_reg;
    logic [DUTY_W-1:0] out_duty_reg;
    logic              out_reached_reg, out_all_reg, out_last_reg;

    logic [CW-1:0]  item_ch_ext;
    logic [CW-1:0]  rd_addr_ext;
    logic [IW-1:0]  rd_addr;
    logic           item_in_range;
    logic           is_pwr_row;
    logic           out_free;
    logic           wr_en;
    row_t           cur_row, wr_row;
    logic           old_miss, new_miss;

    assign item_ch_ext   = CW'(item_ch_reg);
    assign rd_addr_ext   = CW'(rd_addr_reg);
    assign item_in_range = CMP_W'(item_ch_reg) < CMP_W'(CHANNELS);
    assign is_pwr_row    = CMP_W'(rd_addr_reg) == CMP_W'(POWER_CHANNEL);
    assign rd_addr       = (cmd.rd_sel == RD_SWEEP) ? idx_reg : item_ch_ext[IW-1:0];
    assign cur_row       = rd_vld_reg ? rd_row_reg : '0;
    assign out_free      = !out_vld_reg || m_tready;

    assign status.pre_zero    = (pre_reg == '0);
    assign status.idx_last    = (idx_reg == IW'(CHANNELS - 1));
    assign status.ch_in_range = item_in_range;
    assign status.out_free    = out_free;

    // write-back row and speed update
    always_comb
    begin
        wr_row     = cur_row;
        speed_next = speed_reg;
        wr_en      = (cmd.wr_op != WR_NONE);
        case (cmd.wr_op)
            WR_STEP:
            begin
                if (cur_row.cur < cur_row.tgt)
                begin
                    wr_row.cur = cur_row.cur + 8'd1;
                end
                else if (cur_row.cur > cur_row.tgt)
                begin
                    wr_row.cur = cur_row.cur - 8'd1;
                end
            end
            WR_REFRESH:
            begin
                if (item_pwr_reg)
                begin
                    if (cur_row.sw)
                    begin
                        wr_row.tgt = normal_reg;
                    end
                    speed_next = '0;
                end
                else if (is_pwr_row && (cur_row.tgt == cur_row.cur))
                begin
                    // breathing: swing between normal and lowlight once settled
                    if ((cur_row.tgt == '0) || (cur_row.tgt == lowlight_reg))
                    begin
                        wr_row.tgt = normal_reg;
                    end
                    else if (cur_row.tgt == normal_reg)
                    begin
                        wr_row.tgt = lowlight_reg;
                        speed_next = slow_reg;
                    end
                end
                if (!cur_row.sw)
                begin
                    wr_row.tgt = '0;
                end
            end
            WR_SET:
            begin
                wr_row.sw = item_sw_reg;
                if (!item_hl_reg && item_now_reg)
                begin
                    wr_row.cur = item_sw_reg ? normal_reg : '0;
                    wr_row.tgt = item_sw_reg ? normal_reg : '0;
                end
            end
            default: ;
        endcase
    end

    assign old_miss = (cur_row.cur != cur_row.tgt);
    assign new_miss = (wr_row.cur != wr_row.tgt);

    // channel memory: write back at the last read address, read one row a cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            row_mem_reg[rd_addr_reg] <= wr_row;
        end
        if (cmd.rd_en)
        begin
            rd_row_reg  <= row_mem_reg[rd_addr];
            rd_addr_reg <= rd_addr;
        end
    end

    // item latch and output payload
    always_ff @(posedge clk)
    begin
        if (cmd.item_load)
        begin
            item_ch_reg  <= s_tdata[CH_W-1:0];
            item_sw_reg  <= s_tdata[CH_W];
            item_hl_reg  <= s_tdata[CH_W+1];
            item_now_reg <= s_tdata[CH_W+2];
            item_pwr_reg <= s_tdata[CH_W+3];
        end
        if (cmd.out_op == OUT_ROW)
        begin
            out_ch_reg      <= rd_addr_ext[CH_W-1:0];
            out_duty_reg    <= cur_row.cur;
            out_reached_reg <= (cur_row.cur == cur_row.tgt);
            out_all_reg     <= (miss_cnt_reg == '0);
            out_last_reg    <= cmd.out_last;
        end
        else if (cmd.out_op == OUT_QUERY)
        begin
            out_ch_reg      <= item_ch_reg;
            out_duty_reg    <= item_in_range ? cur_row.cur : '0;
            out_reached_reg <= item_in_range ? (cur_row.cur == cur_row.tgt) : 1'b1;
            out_all_reg     <= (miss_cnt_reg == '0);
            out_last_reg    <= cmd.out_last;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            normal_reg   <= NORMAL_RESET;
            lowlight_reg <= LOWLIGHT_RESET;
            slow_reg     <= SLOW_RESET;
            speed_reg    <= '0;
            pre_reg      <= '0;
            idx_reg      <= '0;
            miss_cnt_reg <= '0;
            valid_reg    <= '0;
            rd_vld_reg   <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_NORMAL:   normal_reg   <= cfg_data;
                    CFG_LOWLIGHT: lowlight_reg <= cfg_data;
                    CFG_SLOW:     slow_reg     <= cfg_data;
                    default: ;
                endcase
            end
            speed_reg <= speed_next;
            if (cmd.pre_reload)
            begin
                pre_reg <= speed_reg;
            end
            else if (cmd.pre_dec)
            begin
                pre_reg <= pre_reg - 8'd1;
            end
            if (cmd.idx_clr)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.rd_en)
            begin
                rd_vld_reg <= valid_reg[rd_addr];
            end
            if (wr_en)
            begin
                valid_reg[rd_addr_reg] <= 1'b1;
                miss_cnt_reg <= miss_cnt_reg + CNT_W'(new_miss) - CNT_W'(old_miss);
            end
            if (cmd.out_op != OUT_NONE)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {1'b0, out_all_reg, out_reached_reg, out_duty_reg, out_ch_reg};

    // count of unsettled channels can never exceed the channel count
    a_miss_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        miss_cnt_reg <= CNT_W'(CHANNELS))
        else $error("unsettled channel count out of range");

    // write-back and read never hit the same row in one cycle
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && cmd.rd_en) |-> (rd_addr != rd_addr_reg))
        else $error("read and write of the same channel row");

    // a result is loaded only when the output register is free
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_op != OUT_NONE) |-> out_free)
        else $error("result overwrote a pending transfer");

endmodule

`default_nettype wire

// ===== hdl/led_channel_fade_breathing.sv =====
// Top level: LED channel fade and breathing controller.
// Tick: decrements a nonzero prescaler, else reloads it and sweeps the rows, one row per
// cycle. Refresh: a sweep, then each result is read and sent, waiting while the sink stalls.
// Set switch: row read, then write; a channel out of range skips both. Query: a row read, then
// a wait while a stalled sink holds the output register. Results leave from an output register.
// Reset (async, active low) clears control state; channel rows read as zero until written.
`default_nettype none

module led_channel_fade_breathing
#(
    parameter int CHANNELS      = 17,
    parameter int POWER_CHANNEL = 3
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [lcfb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [lcfb_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // channel[4:0], switch_on[5], highlight[6], update_now[7], power_on[8], zero fill
    input  wire logic [lcfb_pkg::TDATA_W-1:0]   s_tdata,
    // action[1:0]
    input  wire logic [lcfb_pkg::ACT_W-1:0]     s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // out_channel[4:0], duty[12:5], reached[13], all_reached[14], zero fill
    output logic [lcfb_pkg::TDATA_W-1:0]        m_tdata,
    output logic                                m_tlast
);
    import lcfb_pkg::*;

    cmd_t    cmd;
    status_t status;
    action_t action;

    assign action = action_t'(s_tuser);

    lcfb_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .action   (action),
        .status   (status),
        .cmd      (cmd)
    );

    lcfb_datapath
    #(
        .CHANNELS      (CHANNELS),
        .POWER_CHANNEL (POWER_CHANNEL)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

// ===== sim/lcfb_checker.sv =====
// Checker: tracks LED channel state from accepted transfers and compares every result.
`timescale 1ns / 100ps

module lcfb_checker
#(
    parameter int CHANNELS      = 17,
    parameter int POWER_CHANNEL = 3
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [lcfb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [lcfb_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                           s_tvalid,
    input  wire logic                           s_tready,
    // channel[4:0], switch_on[5], highlight[6], update_now[7], power_on[8], zero fill
    input  wire logic [lcfb_pkg::TDATA_W-1:0]   s_tdata,
    // action[1:0]
    input  wire logic [lcfb_pkg::ACT_W-1:0]     s_tuser,
    input  wire logic                           m_tvalid,
    input  wire logic                           m_tready,
    // out_channel[4:0], duty[12:5], reached[13], all_reached[14], zero fill
    input  wire logic [lcfb_pkg::TDATA_W-1:0]   m_tdata,
    input  wire logic                           m_tlast,
    output int                                  errors,
    output int                                  pending
);
    import lcfb_pkg::*;

    // breathing channel index, only used when it is in range
    localparam int BREATHE_CH = POWER_CHANNEL % CHANNELS;

    typedef struct packed {
        logic [CH_W-1:0]   ch;
        logic [DUTY_W-1:0] duty;
        logic              reached;
        logic              all;
        logic              last;
    } duty_report_t;

    logic [DUTY_W-1:0] fade_level [CHANNELS];
    logic [DUTY_W-1:0] fade_goal  [CHANNELS];
    logic              ch_enabled [CHANNELS];
    logic [DUTY_W-1:0] step_reload;
    logic [DUTY_W-1:0] step_count;
    logic [DUTY_W-1:0] cfg_normal;
    logic [DUTY_W-1:0] cfg_low;
    logic [DUTY_W-1:0] cfg_slow;

    duty_report_t duty_reports [$];

    function automatic logic all_settled();
        for (int i = 0; i < CHANNELS; i++)
            if (fade_level[i] != fade_goal[i])
                return 1'b0;
        return 1'b1;
    endfunction

    // queue the report of one channel as the block should send it
    task automatic push_report(input logic [CH_W-1:0] ch, input logic last);
        duty_report_t r;
        r.ch   = ch;
        r.all  = all_settled();
        r.last = last;
        if (ch < CHANNELS)
        begin
            r.duty    = fade_level[ch];
            r.reached = (fade_level[ch] == fade_goal[ch]);
        end
        else
        begin
            r.duty    = '0;
            r.reached = 1'b1;
        end
        duty_reports.push_back(r);
    endtask

    // state update for one accepted command
    task automatic apply_command(input action_t act, input logic [TDATA_W-1:0] word);
        logic [CH_W-1:0]   ch;
        logic              sw;
        logic              hl;
        logic              now;
        logic              pwr;
        logic [DUTY_W-1:0] level;
        ch  = word[4:0];
        sw  = word[5];
        hl  = word[6];
        now = word[7];
        pwr = word[8];
        case (act)
            ACT_TICK:
            begin
                if (step_count != 0)
                    step_count = step_count - 1'b1;
                else
                begin
                    step_count = step_reload;
                    for (int i = 0; i < CHANNELS; i++)
                        if (fade_level[i] < fade_goal[i])
                            fade_level[i] = fade_level[i] + 1'b1;
                        else if (fade_level[i] > fade_goal[i])
                            fade_level[i] = fade_level[i] - 1'b1;
                end
            end
            ACT_REFRESH:
            begin
                if (pwr)
                begin
                    for (int i = 0; i < CHANNELS; i++)
                        if (ch_enabled[i])
                            fade_goal[i] = cfg_normal;
                    step_reload = '0;
                end
                else if (POWER_CHANNEL < CHANNELS)
                begin
                    // breathing turns around only once the power channel has settled
                    if (fade_goal[BREATHE_CH] == fade_level[BREATHE_CH])
                    begin
                        if (fade_goal[BREATHE_CH] == 0 || fade_goal[BREATHE_CH] == cfg_low)
                            fade_goal[BREATHE_CH] = cfg_normal;
                        else if (fade_goal[BREATHE_CH] == cfg_normal)
                        begin
                            fade_goal[BREATHE_CH] = cfg_low;
                            step_reload = cfg_slow;
                        end
                    end
                end
                for (int i = 0; i < CHANNELS; i++)
                    if (!ch_enabled[i])
                        fade_goal[i] = '0;
                for (int i = 0; i < CHANNELS; i++)
                    push_report(CH_W'(i), i == CHANNELS - 1);
            end
            ACT_SET:
            begin
                if (ch < CHANNELS)
                begin
                    ch_enabled[ch] = sw;
                    // immediate jump when update_now is set and no highlight is requested
                    if (!hl && now)
                    begin
                        level = sw ? cfg_normal : '0;
                        fade_level[ch] = level;
                        fade_goal[ch]  = level;
                    end
                end
            end
            default:
                push_report(ch, 1'b1);
        endcase
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // compare one result transfer with the oldest expected report
    task automatic check_report();
        duty_report_t want;
        if (duty_reports.size() == 0)
        begin
            $error("unexpected result for out_channel %0d", m_tdata[4:0]);
            errors++;
        end
        else
        begin
            want = duty_reports.pop_front();
            check_field("out_channel", want.ch, m_tdata[4:0]);
            check_field("duty", want.duty, m_tdata[12:5]);
            check_field("reached", want.reached, m_tdata[13]);
            check_field("all_reached", want.all, m_tdata[14]);
            check_field("last", want.last, m_tlast);
        end
    endtask

    // watch configuration, input and output channels
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                fade_level[i] = '0;
                fade_goal[i]  = '0;
                ch_enabled[i] = 1'b0;
            end
            step_reload = '0;
            step_count  = '0;
            cfg_normal  = NORMAL_RESET;
            cfg_low     = LOWLIGHT_RESET;
            cfg_slow    = SLOW_RESET;
            duty_reports.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_we)
                case (cfg_index)
                    CFG_NORMAL:   cfg_normal = cfg_data;
                    CFG_LOWLIGHT: cfg_low    = cfg_data;
                    CFG_SLOW:     cfg_slow   = cfg_data;
                    default:      ;
                endcase
            if (s_tvalid && s_tready)
                apply_command(action_t'(s_tuser), s_tdata);
            if (m_tvalid && m_tready)
                check_report();
            pending = duty_reports.size();
        end
    end

endmodule

// ===== sim/tb_led_channel_fade_breathing.sv =====
// Testbench top: clock, reset, stimulus and verdict for the LED fade and breathing controller.
`timescale 1ns / 100ps

module tb_led_channel_fade_breathing;
    import lcfb_pkg::*;

    localparam int CHANNELS      = 17;
    localparam int POWER_CHANNEL = 3;
    // covers the longest item without results (a stepping tick) with margin
    localparam int SETTLE_CYCLES = 40;
    localparam int ITEMS_PER_PHASE = 50;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [TDATA_W-1:0]   s_tdata;
    logic [ACT_W-1:0]     s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [TDATA_W-1:0]   m_tdata;
    logic                 m_tlast;
    int                   chk_errors;
    int                   chk_pending;

    // sender burst state and idling knobs
    int burst_left = 0;
    int gap_max    = 0;
    int stall_mode = 1;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    led_channel_fade_breathing
    #(
        .CHANNELS      (CHANNELS),
        .POWER_CHANNEL (POWER_CHANNEL)
    )
    u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    lcfb_checker
    #(
        .CHANNELS      (CHANNELS),
        .POWER_CHANNEL (POWER_CHANNEL)
    )
    u_check
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .errors    (chk_errors),
        .pending   (chk_pending)
    );

    // write all three registers back to back; block must be idle
    task automatic write_config(input logic [7:0] nrm, input logic [7:0] low,
                                input logic [7:0] slw);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_NORMAL;
        cfg_data  <= nrm;
        @(negedge clk);
        cfg_index <= CFG_LOWLIGHT;
        cfg_data  <= low;
        @(negedge clk);
        cfg_index <= CFG_SLOW;
        cfg_data  <= slw;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    // one input transfer; valid stays high across a burst
    task automatic send_item(input action_t act, input logic [4:0] ch, input logic sw,
                             input logic hl, input logic now, input logic pwr);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            if (gap_max != 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, gap_max)) @(negedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {7'd0, pwr, now, hl, sw, ch};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // stop sending until every expected result is back and the block is idle
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (chk_pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // receiver stall pattern
    initial
    begin
        int stall_left;
        stall_left = 0;
        m_tready   = 1'b0;
        forever
        begin
            @(negedge clk);
            case (stall_mode)
                0: m_tready <= 1'b1;
                1:
                begin
                    if (stall_left > 0)
                    begin
                        stall_left--;
                        m_tready <= 1'b0;
                    end
                    else if ($urandom_range(0, 4) == 0)
                    begin
                        stall_left = $urandom_range(0, 7);
                        m_tready <= 1'b0;
                    end
                    else
                        m_tready <= 1'b1;
                end
                default: m_tready <= ~m_tready;
            endcase
        end
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("tb_led_channel_fade_breathing: done, errors");
        $finish;
    end

    // stimulus
    initial
    begin
        action_t    act;
        logic [4:0] ch;
        int         roll;
        int         pwr_pct;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = ACT_TICK;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: reset state, range edges, highlight, power on/off turnarounds
        send_item(ACT_QUERY, 5'd0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_item(ACT_QUERY, 5'(CHANNELS - 1), 1'b0, 1'b0, 1'b0, 1'b0);
        send_item(ACT_QUERY, 5'd31, 1'b1, 1'b1, 1'b1, 1'b1);
        send_item(ACT_SET, 5'(POWER_CHANNEL), 1'b1, 1'b0, 1'b0, 1'b0);
        // settled at zero with power off: goes to normal
        send_item(ACT_REFRESH, 5'd0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_item(ACT_SET, 5'(POWER_CHANNEL), 1'b1, 1'b0, 1'b1, 1'b0);
        send_item(ACT_SET, 5'(CHANNELS - 1), 1'b1, 1'b1, 1'b1, 1'b0);
        send_item(ACT_SET, 5'd31, 1'b1, 1'b0, 1'b1, 1'b0);
        send_item(ACT_SET, 5'(CHANNELS), 1'b1, 1'b0, 1'b1, 1'b0);
        send_item(ACT_REFRESH, 5'd0, 1'b0, 1'b0, 1'b0, 1'b1);
        send_item(ACT_TICK, 5'd0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_item(ACT_TICK, 5'd0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_item(ACT_QUERY, 5'(CHANNELS - 1), 1'b0, 1'b0, 1'b0, 1'b0);
        // settled at normal with power off: dims to lowlight at slow speed
        send_item(ACT_REFRESH, 5'd0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_item(ACT_TICK, 5'd0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_item(ACT_TICK, 5'd0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_item(ACT_QUERY, 5'(POWER_CHANNEL), 1'b0, 1'b0, 1'b0, 1'b0);
        send_item(ACT_SET, 5'(CHANNELS - 1), 1'b0, 1'b0, 1'b1, 1'b0);
        send_item(ACT_SET, 5'd0, 1'b1, 1'b0, 1'b0, 1'b0);
        // power channel still fading: target left alone
        send_item(ACT_REFRESH, 5'd0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_item(ACT_REFRESH, 5'd0, 1'b0, 1'b0, 1'b0, 1'b1);
        send_item(ACT_QUERY, 5'(CHANNELS), 1'b0, 1'b0, 1'b0, 1'b0);
        drain_results();

        // random phases, each with its own register setting and idling mix
        for (int phase = 0; phase < 6; phase++)
        begin
            gap_max    = (phase % 3 == 0) ? 0 : ((phase % 3 == 1) ? 4 : 10);
            stall_mode = (phase + 1) % 3;
            pwr_pct    = (phase >= 3) ? 20 : 50;
            case (phase)
                1: write_config(8'd0, 8'd0, 8'd0);
                2: write_config(8'd255, 8'd255, 8'd255);
                3: write_config(8'd40, 8'd32, 8'd1);
                4: write_config(8'd9, 8'd3, 8'd0);
                5: write_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                8'($urandom_range(0, 3)));
                default: ;
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (n == ITEMS_PER_PHASE / 2 && phase % 2 == 1)
                    drain_results();
                roll = $urandom_range(0, 99);
                if (roll < 50)
                    act = ACT_TICK;
                else if (roll < 68)
                    act = ACT_REFRESH;
                else if (roll < 88)
                    act = ACT_SET;
                else
                    act = ACT_QUERY;
                // mostly valid channels, power channel favored, some out of range
                roll = $urandom_range(0, 9);
                if (roll == 0)
                    ch = 5'($urandom_range(CHANNELS, 31));
                else if (roll < 4)
                    ch = 5'(POWER_CHANNEL);
                else
                    ch = 5'($urandom_range(0, CHANNELS - 1));
                send_item(act, ch, $urandom_range(0, 3) != 0, $urandom_range(0, 3) == 0,
                          1'($urandom_range(0, 1)), $urandom_range(0, 99) < pwr_pct);
            end
            drain_results();
        end

        if (chk_errors == 0 && chk_pending == 0)
            $display("tb_led_channel_fade_breathing: done, clean");
        else
            $display("tb_led_channel_fade_breathing: done, errors");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/lcfb_pkg.sv
hdl/lcfb_ctrl.sv
hdl/lcfb_datapath.sv
hdl/led_channel_fade_breathing.sv
sim/lcfb_checker.sv
sim/tb_led_channel_fade_breathing.sv
